// ===== hw/rtl/pamt_pkg.sv =====
// shared types, widths and constants for the pwm angle multiturn tracker
package pamt_pkg;

  localparam int RESOLUTION_DEF = 4096;

  // field widths
  localparam int AGE_W      = 24;
  localparam int TIME_W     = 16;
  localparam int START_W    = 12;
  localparam int STATUS_W   = 2;
  localparam int POS_W      = 32;
  localparam int FRAME_W    = 13;
  localparam int PRE_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // product of high time and frame counts plus half the period fits in 30 bits
  localparam int PROD_W    = TIME_W + FRAME_W;
  localparam int DIV_W     = PROD_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // request codes
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_RESET = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOT_INIT = 2'd1,
    ST_NOT_CONN = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STALE_LIMIT = 3'd0,
    REG_CLOCKWISE   = 3'd1,
    REG_INITIALIZED = 3'd2,
    REG_FRAME       = 3'd3,
    REG_PREAMBLE    = 3'd4
  } cfg_reg_t;

  // register reset values
  localparam logic [AGE_W-1:0]   STALE_LIMIT_RST = 24'd100000;
  localparam logic               CLOCKWISE_RST   = 1'b0;
  localparam logic               INITIALIZED_RST = 1'b0;
  localparam logic [FRAME_W-1:0] FRAME_RST       = 13'd4351;
  localparam logic [PRE_W-1:0]   PREAMBLE_RST    = 10'd128;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

// ===== hw/rtl/pamt_if.sv =====
// channel interfaces: sample request, result and register write
interface pamt_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic                          sample_present;
  logic [pamt_pkg::AGE_W-1:0]    sample_age_us;
  logic [pamt_pkg::TIME_W-1:0]   high_us;
  logic [pamt_pkg::TIME_W-1:0]   period_us;
  logic [pamt_pkg::START_W-1:0]  start_raw;

  modport source (output valid, req_type, sample_present, sample_age_us, high_us, period_us,
                  start_raw, input ready);
  modport sink (input valid, req_type, sample_present, sample_age_us, high_us, period_us,
                start_raw, output ready);
endinterface

interface pamt_out_if;
  logic                          valid;
  logic                          ready;
  logic [pamt_pkg::STATUS_W-1:0] status;
  logic signed [pamt_pkg::POS_W-1:0] position;

  modport source (output valid, status, position, input ready);
  modport sink (input valid, status, position, output ready);
endinterface

interface pamt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pamt_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [pamt_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== hw/rtl/pamt_ctrl.sv =====
// controller state machine: accept, multiply, divide, commit result
module pamt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pamt_pkg::dp_stat_t stat,
  output pamt_pkg::dp_cmd_t  cmd
);

  pamt_pkg::ctrl_state_t state, state_next;
  logic out_full, out_full_next;
  logic can_commit;

  assign can_commit = !out_full || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pamt_pkg::S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pamt_pkg::S_IDLE: if (in_valid) state_next = pamt_pkg::S_MUL;
      pamt_pkg::S_MUL:  state_next = pamt_pkg::S_DIV;
      pamt_pkg::S_DIV:  if (stat.div_done) state_next = pamt_pkg::S_FIN;
      pamt_pkg::S_FIN:  if (can_commit) state_next = pamt_pkg::S_IDLE;
      default:          state_next = pamt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      pamt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      pamt_pkg::S_MUL:  cmd.mul = 1'b1;
      pamt_pkg::S_DIV:  cmd.step = 1'b1;
      pamt_pkg::S_FIN:  cmd.commit = can_commit;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  // output register holds one result until the sink takes it
  always_comb begin
    priority if (cmd.commit) begin
      out_full_next = 1'b1;
    end else if (out_ready) begin
      out_full_next = 1'b0;
    end else begin
      out_full_next = out_full;
    end
  end

  assign out_valid = out_full;

endmodule

// ===== hw/rtl/pamt_datapath.sv =====
// datapath: config registers, duty multiply, serial divider, unwrap and count
module pamt_datapath #(
  parameter int RESOLUTION = pamt_pkg::RESOLUTION_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pamt_pkg::dp_cmd_t                  cmd,
  output pamt_pkg::dp_stat_t                 stat,
  input  logic                               req_type,
  input  logic                               sample_present,
  input  logic [pamt_pkg::AGE_W-1:0]         sample_age_us,
  input  logic [pamt_pkg::TIME_W-1:0]        high_us,
  input  logic [pamt_pkg::TIME_W-1:0]        period_us,
  input  logic [pamt_pkg::START_W-1:0]       start_raw,
  input  logic                               cfg_we,
  input  logic [pamt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pamt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic [pamt_pkg::STATUS_W-1:0]      status,
  output logic signed [pamt_pkg::POS_W-1:0]  position
);

  localparam int RAW_W = $clog2(RESOLUTION);
  localparam int DW    = pamt_pkg::DIV_W;
  localparam int TW    = pamt_pkg::TIME_W;
  localparam int PW    = pamt_pkg::POS_W;
  localparam logic [RAW_W-1:0]     RAW_MAX = RAW_W'(RESOLUTION - 1);
  localparam logic signed [PW-1:0] HALF_S  = PW'(RESOLUTION / 2);
  localparam logic signed [PW-1:0] RES_S   = PW'(RESOLUTION);

  // configuration registers
  logic [pamt_pkg::AGE_W-1:0]   stale_limit_us;
  logic                         clockwise;
  logic                         initialized;
  logic [pamt_pkg::FRAME_W-1:0] frame_counts;
  logic [pamt_pkg::PRE_W-1:0]   preamble_counts;

  // latched item
  logic                         req_q;
  logic                         present_q;
  logic [pamt_pkg::AGE_W-1:0]   age_q;
  logic [TW-1:0]                high_q;
  logic [TW-1:0]                period_q;
  logic [pamt_pkg::START_W-1:0] start_q;

  // divider
  logic [DW-1:0]                  dvd;
  logic [TW-1:0]                  rem;
  logic [pamt_pkg::DIV_CNT_W-1:0] cnt;
  logic [pamt_pkg::PROD_W-1:0]    prod;
  logic [DW-1:0]                  dividend;
  logic [TW:0]                    trial;
  logic                           trial_ge;

  // tracking state
  logic [RAW_W-1:0] last_raw;
  logic [PW-1:0]    turn_count;
  logic             have_first;

  // commit logic
  logic                     sample_ok;
  logic                     above_pre;
  logic [DW-1:0]            val;
  logic [RAW_W-1:0]         cur_read;
  logic [RAW_W-1:0]         cur_start;
  logic [RAW_W-1:0]         cur;
  logic signed [RAW_W+1:0]  diff0;
  logic signed [PW-1:0]     diff_w;
  logic signed [PW-1:0]     diff_adj;
  logic [PW-1:0]            turn_new;
  pamt_pkg::status_t        st;
  logic                     accumulate;

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit_us  <= pamt_pkg::STALE_LIMIT_RST;
      clockwise       <= pamt_pkg::CLOCKWISE_RST;
      initialized     <= pamt_pkg::INITIALIZED_RST;
      frame_counts    <= pamt_pkg::FRAME_RST;
      preamble_counts <= pamt_pkg::PREAMBLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pamt_pkg::REG_STALE_LIMIT: stale_limit_us  <= cfg_wdata;
        pamt_pkg::REG_CLOCKWISE:   clockwise       <= cfg_wdata[0];
        pamt_pkg::REG_INITIALIZED: initialized     <= cfg_wdata[0];
        pamt_pkg::REG_FRAME:       frame_counts    <= cfg_wdata[pamt_pkg::FRAME_W-1:0];
        pamt_pkg::REG_PREAMBLE:    preamble_counts <= cfg_wdata[pamt_pkg::PRE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q     <= req_type;
      present_q <= sample_present;
      age_q     <= sample_age_us;
      high_q    <= high_us;
      period_q  <= period_us;
      start_q   <= start_raw;
    end
  end

  assign prod     = pamt_pkg::PROD_W'(high_q) * pamt_pkg::PROD_W'(frame_counts);
  assign dividend = DW'(prod) + DW'(period_q[TW-1:1]);

  // restoring division, one quotient bit per cycle shifted into dvd
  assign trial    = {rem, dvd[DW-1]};
  assign trial_ge = trial >= {1'b0, period_q};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      dvd <= dividend;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.step) begin
      dvd <= {dvd[DW-2:0], trial_ge};
      rem <= trial_ge ? TW'(trial - {1'b0, period_q}) : trial[TW-1:0];
      cnt <= cnt + 1'b1;
    end
  end

  assign stat.div_done = cmd.step && (cnt == pamt_pkg::DIV_CNT_W'(DW - 1));

  // raw angle from the quotient, clamped to the resolution
  assign sample_ok = (period_q != '0) && (high_q <= period_q);
  assign above_pre = dvd > DW'(preamble_counts);
  assign val       = dvd - DW'(preamble_counts);

  always_comb begin
    priority if (!above_pre) begin
      cur_read = '0;
    end else if (val >= DW'(RESOLUTION)) begin
      cur_read = RAW_MAX;
    end else begin
      cur_read = val[RAW_W-1:0];
    end
  end

  assign cur_start = (PW'(start_q) > PW'(RESOLUTION - 1)) ? RAW_MAX : RAW_W'(start_q);
  assign cur       = (req_q == pamt_pkg::REQ_RESET && start_q != '0) ? cur_start : cur_read;

  always_comb begin
    priority if (!initialized) begin
      st = pamt_pkg::ST_NOT_INIT;
    end else if (req_q == pamt_pkg::REQ_READ) begin
      st = (!present_q || age_q > stale_limit_us || !sample_ok) ? pamt_pkg::ST_NOT_CONN
                                                                 : pamt_pkg::ST_OK;
    end else if (start_q == '0) begin
      st = (!present_q || !sample_ok) ? pamt_pkg::ST_NOT_CONN : pamt_pkg::ST_OK;
    end else begin
      st = pamt_pkg::ST_OK;
    end
  end

  // unwrap the step into plus or minus half a turn
  assign diff0  = $signed({2'b00, cur}) - $signed({2'b00, last_raw});
  assign diff_w = PW'(diff0);

  always_comb begin
    priority if (diff_w > HALF_S) begin
      diff_adj = diff_w - RES_S;
    end else if (diff_w < -HALF_S) begin
      diff_adj = diff_w + RES_S;
    end else begin
      diff_adj = diff_w;
    end
  end

  assign turn_new   = clockwise ? turn_count - $unsigned(diff_adj)
                                : turn_count + $unsigned(diff_adj);
  assign accumulate = (req_q == pamt_pkg::REQ_READ) && have_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_first <= 1'b0;
      last_raw   <= '0;
      turn_count <= '0;
    end else if (cmd.commit && st == pamt_pkg::ST_OK) begin
      have_first <= 1'b1;
      last_raw   <= cur;
      turn_count <= accumulate ? turn_new : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status   <= st;
      position <= (st == pamt_pkg::ST_OK && accumulate) ? $signed(turn_new) : '0;
    end
  end

endmodule

// ===== hw/rtl/pwm_angle_multiturn_tracker.sv =====
// top level of the pwm duty angle decoder with multiturn count
// an item passes through the multiply, the divide steps and the commit before its result is valid
// the bit-serial divider of the duty quotient keeps the block busy with one item at a time
// a result waits in an output register; the next item is taken once it is committed
// reset (rst, synchronous) restores register defaults and clears the tracking state
module pwm_angle_multiturn_tracker #(
  parameter int RESOLUTION = pamt_pkg::RESOLUTION_DEF
) (
  input logic          clk,
  input logic          rst,
  pamt_in_if.sink      sample_in,
  pamt_out_if.source   result_out,
  pamt_cfg_if.sink     cfg
);

  pamt_pkg::dp_cmd_t  cmd;
  pamt_pkg::dp_stat_t stat;

  assign cfg.ready = 1'b1;

  pamt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pamt_datapath #(
    .RESOLUTION (RESOLUTION)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_type       (sample_in.req_type),
    .sample_present (sample_in.sample_present),
    .sample_age_us  (sample_in.sample_age_us),
    .high_us        (sample_in.high_us),
    .period_us      (sample_in.period_us),
    .start_raw      (sample_in.start_raw),
    .cfg_we         (cfg.valid && cfg.ready),
    .cfg_index      (cfg.reg_index),
    .cfg_wdata      (cfg.wdata),
    .status         (result_out.status),
    .position       (result_out.position)
  );

  // status code 3 is never produced
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> result_out.status != 2'd3)
    else $error("result status out of range");

  // an error result carries no position
  a_err_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.status != pamt_pkg::ST_OK) |-> result_out.position == '0)
    else $error("error result with nonzero position");

  // after an input transfer the block is busy with that item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample_in.valid && sample_in.ready) |=> !sample_in.ready)
    else $error("input taken while an item is in progress");

  // a result never appears in the cycle after an input transfer
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (sample_in.valid && sample_in.ready && !result_out.valid) |=> !result_out.valid)
    else $error("result appeared before the divide finished");

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the pwm angle multiturn tracker: directed and random sample requests
module tb_top;
  import pamt_pkg::*;

  localparam int RAW_W       = $clog2(RESOLUTION_DEF);
  localparam int HALF_TURN   = RESOLUTION_DEF / 2;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SHOW_MAX    = 10;

  typedef struct packed {
    logic                req_type;
    logic                sample_present;
    logic [AGE_W-1:0]    age;
    logic [TIME_W-1:0]   high;
    logic [TIME_W-1:0]   period;
    logic [START_W-1:0]  start;
  } sample_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [POS_W-1:0]  position;
  } angle_result_t;

  // predicts status and cumulative position per request, checks results in order
  class angle_tracker_sb;
    logic [AGE_W-1:0]   stale_limit;
    logic               cw;
    logic               init_done;
    logic [FRAME_W-1:0] frame;
    logic [PRE_W-1:0]   pre;
    logic [RAW_W-1:0]   zero_raw;
    logic [RAW_W-1:0]   last_raw;
    logic [POS_W-1:0]   turn_count;
    bit                 have_first;
    angle_result_t      pending_q[$];
    int                 errors;

    function new();
      stale_limit = STALE_LIMIT_RST;
      cw          = CLOCKWISE_RST;
      init_done   = INITIALIZED_RST;
      frame       = FRAME_RST;
      pre         = PREAMBLE_RST;
      zero_raw    = '0;
      last_raw    = '0;
      turn_count  = '0;
      have_first  = 0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_STALE_LIMIT: stale_limit = d[AGE_W-1:0];
        REG_CLOCKWISE:   cw          = d[0];
        REG_INITIALIZED: init_done   = d[0];
        REG_FRAME:       frame       = d[FRAME_W-1:0];
        REG_PREAMBLE:    pre         = d[PRE_W-1:0];
        default: ;
      endcase
    endfunction

    // rounded duty quotient minus preamble, clamped to one turn
    function bit raw_angle(logic [TIME_W-1:0] high, logic [TIME_W-1:0] period,
                           output logic [RAW_W-1:0] raw);
      logic [63:0] scaled;
      raw = '0;
      if (period == 0 || high > period) return 0;
      scaled = (64'(high) * 64'(frame) + 64'(period >> 1)) / 64'(period);
      if (scaled <= 64'(pre)) raw = '0;
      else if (scaled - 64'(pre) >= 64'(RESOLUTION_DEF)) raw = RAW_W'(RESOLUTION_DEF - 1);
      else raw = RAW_W'(scaled - 64'(pre));
      return 1;
    endfunction

    function void note_request(sample_item_t it);
      angle_result_t    r;
      logic [RAW_W-1:0] cur;
      int               diff;
      bit               good;
      r.status   = ST_OK;
      r.position = '0;
      cur        = '0;
      if (!init_done) begin
        r.status = ST_NOT_INIT;
      end else if (it.req_type == REQ_READ) begin
        good = raw_angle(it.high, it.period, cur);
        if (!it.sample_present || it.age > stale_limit || !good) begin
          r.status = ST_NOT_CONN;
        end else if (!have_first) begin
          zero_raw   = cur;
          last_raw   = cur;
          turn_count = '0;
          have_first = 1;
        end else begin
          diff = int'(cur) - int'(last_raw);
          if (diff > HALF_TURN) diff -= RESOLUTION_DEF;
          else if (diff < -HALF_TURN) diff += RESOLUTION_DEF;
          if (cw) turn_count = turn_count - POS_W'(diff);
          else turn_count = turn_count + POS_W'(diff);
          last_raw   = cur;
          r.position = turn_count;
        end
      end else begin
        if (it.start == 0) begin
          good = raw_angle(it.high, it.period, cur);
          if (!it.sample_present || !good) r.status = ST_NOT_CONN;
        end else if (int'(it.start) > RESOLUTION_DEF - 1) begin
          cur = RAW_W'(RESOLUTION_DEF - 1);
        end else begin
          cur = RAW_W'(it.start);
        end
        if (r.status == ST_OK) begin
          zero_raw   = cur;
          last_raw   = cur;
          turn_count = '0;
          have_first = 1;
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic signed [POS_W-1:0] pos);
      angle_result_t r;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("result with nothing pending: status %0d position %0d", st, pos);
        return;
      end
      r = pending_q.pop_front();
      if (st !== r.status || pos !== r.position) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("mismatch: expected status %0d position %0d, got status %0d position %0d",
                   r.status, r.position, st, pos);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  pamt_in_if  sample_in();
  pamt_out_if result_out();
  pamt_cfg_if cfg();

  pwm_angle_multiturn_tracker i_dut (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_in),
    .result_out (result_out),
    .cfg        (cfg)
  );

  angle_tracker_sb sb;
  int              cycles;
  int              burst_left;
  int              seg_left;
  int              seg_kind;
  int              shaft_high;
  int              shaft_period;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: segments of full speed, random, hard stall and a duty pattern
  always @(negedge clk) begin
    if (seg_left == 0) begin
      seg_kind = $urandom_range(0, 3);
      seg_left = $urandom_range(1, 80);
    end
    seg_left--;
    case (seg_kind)
      0:       result_out.ready = 1'b1;
      1:       result_out.ready = 1'($urandom_range(0, 1));
      2:       result_out.ready = 1'b0;
      default: result_out.ready = (seg_left % 3) != 0;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && result_out.valid && result_out.ready)
      sb.check_result(result_out.status, result_out.position);
  end

  function automatic sample_item_t mk(logic req, logic present, logic [AGE_W-1:0] age,
                                      logic [TIME_W-1:0] high, logic [TIME_W-1:0] period,
                                      logic [START_W-1:0] start);
    sample_item_t it;
    it.req_type       = req;
    it.sample_present = present;
    it.age            = age;
    it.high           = high;
    it.period         = period;
    it.start          = start;
    return it;
  endfunction

  task automatic drive_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
    cfg.valid     = 1'b1;
    cfg.reg_index = idx;
    cfg.wdata     = d;
    do @(posedge clk); while (!cfg.ready);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic load_config(logic [AGE_W-1:0] stale, logic cw, logic init,
                             logic [FRAME_W-1:0] frame, logic [PRE_W-1:0] pre);
    drive_reg(REG_STALE_LIMIT, CFG_DATA_W'(stale));
    drive_reg(REG_CLOCKWISE, CFG_DATA_W'(cw));
    drive_reg(REG_INITIALIZED, CFG_DATA_W'(init));
    drive_reg(REG_FRAME, CFG_DATA_W'(frame));
    drive_reg(REG_PREAMBLE, CFG_DATA_W'(pre));
  endtask

  // sender works in bursts; a gap of random length opens each burst
  task automatic push_sample(sample_item_t it);
    if (burst_left == 0) begin
      sample_in.valid = 1'b0;
      repeat ($urandom_range(0, 40)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    sample_in.valid          = 1'b1;
    sample_in.req_type       = it.req_type;
    sample_in.sample_present = it.sample_present;
    sample_in.sample_age_us  = it.age;
    sample_in.high_us        = it.high;
    sample_in.period_us      = it.period;
    sample_in.start_raw      = it.start;
    do @(posedge clk); while (!sample_in.ready);
    sb.note_request(it);
    @(negedge clk);
  endtask

  task automatic drain();
    sample_in.valid = 1'b0;
    burst_left      = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic [AGE_W-1:0] fresh_age();
    if ($urandom_range(0, 9) == 0 && sb.stale_limit != {AGE_W{1'b1}})
      return AGE_W'(sb.stale_limit + 1);
    return AGE_W'($urandom_range(0, sb.stale_limit));
  endfunction

  function automatic sample_item_t rand_item();
    int           sel;
    int           step;
    sample_item_t it;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      // shaft turning: small steps, now and then a jump near half a turn
      step = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1200) - 600
                                         : $urandom_range(0, 200) - 100;
      shaft_high += step * shaft_period / 1000;
      if (shaft_high < 0) shaft_high = 0;
      if (shaft_high > shaft_period) shaft_high = shaft_period;
      it = mk(REQ_READ, 1'b1, fresh_age(), TIME_W'(shaft_high), TIME_W'(shaft_period), '0);
    end else if (sel < 70) begin
      shaft_period = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                 : $urandom_range(900, 1100);
      shaft_high   = $urandom_range(0, shaft_period);
      it = mk(REQ_READ, 1'b1, fresh_age(), TIME_W'(shaft_high), TIME_W'(shaft_period), '0);
    end else if (sel < 82) begin
      it = mk(REQ_RESET, 1'($urandom_range(0, 7) != 0), AGE_W'($urandom),
              TIME_W'(shaft_high), TIME_W'(shaft_period),
              ($urandom_range(0, 1) == 0) ? '0 : START_W'($urandom));
    end else begin
      it = mk(1'($urandom), 1'($urandom), AGE_W'($urandom), TIME_W'($urandom),
              TIME_W'($urandom), START_W'($urandom));
    end
    return it;
  endfunction

  task automatic random_phase(int n);
    logic [AGE_W-1:0]   stale;
    logic [FRAME_W-1:0] frame;
    logic [PRE_W-1:0]   pre;
    case ($urandom_range(0, 4))
      0:       stale = '0;
      1:       stale = {AGE_W{1'b1}};
      2:       stale = AGE_W'($urandom);
      default: stale = AGE_W'($urandom_range(1000, 200000));
    endcase
    case ($urandom_range(0, 5))
      0:       frame = FRAME_W'(1);
      1:       frame = {FRAME_W{1'b1}};
      default: frame = FRAME_W'($urandom_range(2000, 8191));
    endcase
    case ($urandom_range(0, 4))
      0:       pre = '0;
      1:       pre = {PRE_W{1'b1}};
      default: pre = PRE_W'($urandom_range(0, 300));
    endcase
    load_config(stale, 1'($urandom), 1'($urandom_range(0, 7) != 0), frame, pre);
    repeat (n) push_sample(rand_item());
    drain();
  endtask

  initial begin
    sb                       = new();
    cycles                   = 0;
    burst_left               = 0;
    seg_left                 = 0;
    seg_kind                 = 0;
    shaft_high               = 500;
    shaft_period             = 1000;
    rst                      = 1'b1;
    sample_in.valid          = 1'b0;
    sample_in.req_type       = REQ_READ;
    sample_in.sample_present = 1'b0;
    sample_in.sample_age_us  = '0;
    sample_in.high_us        = '0;
    sample_in.period_us      = '0;
    sample_in.start_raw      = '0;
    cfg.valid                = 1'b0;
    cfg.reg_index            = REG_STALE_LIMIT;
    cfg.wdata                = '0;
    result_out.ready         = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // not initialized after reset: both request kinds rejected
    push_sample(mk(REQ_READ, 1'b1, '0, 16'd500, 16'd1000, '0));
    push_sample(mk(REQ_RESET, 1'b1, '0, 16'd500, 16'd1000, 12'd7));
    drain();

    // reset defaults for everything but the init flag
    drive_reg(REG_INITIALIZED, CFG_DATA_W'(1));
    push_sample(mk(REQ_READ, 1'b0, '0, 16'd500, 16'd1000, '0));
    push_sample(mk(REQ_READ, 1'b1, '0, 16'd10, 16'd0, '0));
    push_sample(mk(REQ_READ, 1'b1, '0, 16'd1001, 16'd1000, '0));
    push_sample(mk(REQ_READ, 1'b1, 24'd100001, 16'd500, 16'd1000, '0));
    push_sample(mk(REQ_READ, 1'b1, 24'd100000, 16'd0, 16'd1000, '0));
    push_sample(mk(REQ_READ, 1'b1, '0, 16'hFFFF, 16'hFFFF, '0));
    push_sample(mk(REQ_READ, 1'b1, '0, 16'd500, 16'd1000, '0));
    push_sample(mk(REQ_RESET, 1'b0, '0, 16'd250, 16'd1000, '0));
    push_sample(mk(REQ_RESET, 1'b1, '0, 16'd10, 16'd0, '0));
    push_sample(mk(REQ_RESET, 1'b1, 24'hFFFFFF, 16'd250, 16'd1000, '0));
    push_sample(mk(REQ_RESET, 1'b1, '0, '0, '0, 12'hFFF));
    push_sample(mk(REQ_READ, 1'b1, '0, 16'd0, 16'd1, '0));
    push_sample(mk(REQ_RESET, 1'b1, '0, '0, '0, 12'd1));
    push_sample(mk(REQ_READ, 1'b1, '0, 16'd1000, 16'd1000, '0));
    // unwrap edges: a delta of exactly half a turn is kept, one more wraps
    push_sample(mk(REQ_RESET, 1'b1, '0, '0, '0, 12'd2048));
    push_sample(mk(REQ_READ, 1'b1, '0, 16'd0, 16'd1000, '0));
    push_sample(mk(REQ_RESET, 1'b1, '0, '0, '0, 12'd2049));
    push_sample(mk(REQ_READ, 1'b1, '0, 16'd0, 16'd1000, '0));
    push_sample(mk(REQ_RESET, 1'b1, '0, '0, '0, 12'd2047));
    push_sample(mk(REQ_READ, 1'b1, '0, 16'd1000, 16'd1000, '0));
    drain();

    // clockwise, tightest age limit, widest frame, no preamble
    load_config('0, 1'b1, 1'b1, {FRAME_W{1'b1}}, '0);
    push_sample(mk(REQ_READ, 1'b1, 24'd1, 16'd300, 16'd1000, '0));
    push_sample(mk(REQ_READ, 1'b1, '0, 16'd300, 16'd1000, '0));
    push_sample(mk(REQ_READ, 1'b1, '0, 16'd900, 16'd1000, '0));
    push_sample(mk(REQ_READ, 1'b1, '0, 16'd100, 16'd1000, '0));
    drain();

    // zero frame counts: every good sample decodes to angle 0
    load_config({AGE_W{1'b1}}, 1'b0, 1'b1, '0, {PRE_W{1'b1}});
    push_sample(mk(REQ_READ, 1'b1, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, '0));
    push_sample(mk(REQ_RESET, 1'b1, '0, 16'd700, 16'd1000, '0));
    push_sample(mk(REQ_READ, 1'b1, '0, 16'd700, 16'd1000, '0));
    drain();

    repeat (7) random_phase(100);

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/pamt_pkg.sv
hw/rtl/pamt_if.sv
hw/rtl/pamt_ctrl.sv
hw/rtl/pamt_datapath.sv
hw/rtl/pwm_angle_multiturn_tracker.sv
bench/tb_top.sv
